// ----- rtl/fslm_pkg.sv -----
// Shared types, codes and helpers of the fixed-string line matcher.
package fslm_pkg;

    localparam int CNT_W  = 24;
    localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_LINE    = 2'd1,
        CMD_EOL     = 2'd2,
        CMD_NEWFILE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_CASE_INSENSITIVE = 2'd0,
        REG_WHOLE_LINE       = 2'd1,
        REG_INVERT           = 2'd2,
        REG_PATTERNS_IN_USE  = 2'd3
    } reg_idx_t;

    // Status of one pass of the compare unit over one pattern.
    typedef struct packed {
        logic hit;      // pattern ends at this byte
        logic char_ok;  // byte at line position agrees with pattern
        logic len_eq;   // line position equals pattern length
    } cmp_stat_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && (c inside {[8'h41:8'h5A]}))
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

// ----- rtl/fslm_in_if.sv -----
// Input item channel: command beats with valid/ready handshake.
interface fslm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [1:0] pattern_index;
    logic [4:0] byte_position;
    logic [7:0] data_byte;

    modport source (output valid, command, pattern_index, byte_position, data_byte,
                    input ready);
    modport sink   (input valid, command, pattern_index, byte_position, data_byte,
                    output ready);
endinterface

// ----- rtl/fslm_out_if.sv -----
// Result channel: one beat per finished line, valid/ready handshake.
interface fslm_out_if;
    logic        valid;
    logic        ready;
    logic        line_selected;
    logic [23:0] line_number;
    logic [23:0] selected_count;
    logic        any_match;

    modport source (output valid, line_selected, line_number, selected_count, any_match,
                    input ready);
    modport sink   (input valid, line_selected, line_number, selected_count, any_match,
                    output ready);
endinterface

// ----- rtl/fslm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fslm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/fslm_cmp.sv -----
// Shared compare unit: one line byte against one whole pattern row in parallel.
module fslm_cmp #(
    parameter int PATTERN_LEN = 32,
    parameter int LPOS_W      = 6
) (
    input  logic [PATTERN_LEN*8-1:0] row,
    input  logic                     fold_en,
    input  logic [7:0]               ch,
    input  logic [PATTERN_LEN-1:0]   pm_in,
    input  logic [LPOS_W-1:0]        lpos,
    output logic [PATTERN_LEN-1:0]   pm_out,
    output fslm_pkg::cmp_stat_t      stat
);

    localparam int IDX_W = $clog2(PATTERN_LEN);

    logic [PATTERN_LEN-1:0] nz;
    logic [PATTERN_LEN-1:0] inlen;
    logic [PATTERN_LEN-1:0] eq;
    logic [PATTERN_LEN-1:0] lastmask;
    logic [7:0]             ch_f;

    assign ch_f = fslm_pkg::fold_char(ch, fold_en);

    // Per position: nonzero, inside pattern length, byte matches.
    always_comb
    begin
        logic [PATTERN_LEN-1:0] lowmask;
        lowmask = '0;
        for (int k = 0; k < PATTERN_LEN; k++)
        begin
            nz[k] = (row[8*k +: 8] != 8'd0);
        end
        for (int k = 0; k < PATTERN_LEN; k++)
        begin
            lowmask  = {PATTERN_LEN{1'b1}} >> (PATTERN_LEN - 1 - k);
            inlen[k] = &(nz | ~lowmask);
            eq[k]    = inlen[k] && (fslm_pkg::fold_char(row[8*k +: 8], fold_en) == ch_f);
        end
    end

    assign lastmask = inlen & ~(inlen >> 1);
    assign pm_out   = eq & {pm_in[PATTERN_LEN-2:0], 1'b1};

    always_comb
    begin
        stat.hit     = |(pm_out & lastmask);
        stat.char_ok = (32'(lpos) < PATTERN_LEN) && eq[IDX_W'(lpos)];
        stat.len_eq  = ((lpos == '0) && !inlen[0]) ||
                       ((lpos != '0) && (32'(lpos) <= PATTERN_LEN) &&
                        lastmask[IDX_W'(lpos - 1'b1)]);
    end

endmodule

// ----- rtl/fixed_string_line_matcher_core.sv -----
// Top level of the fixed-string line matcher: sequencer, line state, counters, APB.
//
//  channel  | dir | handshake      | beat contents
//  ---------+-----+----------------+-------------------------------------------------
//  item     | in  | valid/ready    | command, pattern_index, byte_position, data_byte
//  result   | out | valid/ready    | line_selected, line_number, selected_count, any_match
//  apb      | in  | psel/penable   | paddr, pwdata, prdata (pready tied high)
//
// Sequencing: one pattern row is read from the store and compared per cycle, so a line
// byte, or a whole-line end of line, is scanned over the N patterns in use (N clamped
// to NUM_PATTERNS; with none in use no scan runs), a pattern load reads the row, merges
// the byte and writes it back, and a substring end of line goes straight to emit.
// Reset: pattern rows are marked empty by per-row valid bits, no clearing pass.
// Stalls: a finished result sits in the output register; the next item is taken
// while it waits, and only a second end of line holds until the first is taken.
module fixed_string_line_matcher_core #(
    parameter int NUM_PATTERNS = 4,
    parameter int PATTERN_LEN  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fslm_pkg::APB_AW-1:0]  paddr,
    input  logic [fslm_pkg::APB_DW-1:0]  pwdata,
    output logic [fslm_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    fslm_in_if.sink                      item,
    fslm_out_if.source                   result
);

    localparam int ROW_W  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int ACT_W  = $clog2(NUM_PATTERNS + 1);
    localparam int LPOS_W = $clog2(PATTERN_LEN + 2);
    localparam int ROW_BITS = PATTERN_LEN * 8;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_LOAD_RD  = 6'b000010,
        ST_LOAD_WR  = 6'b000100,
        ST_SCAN_RD  = 6'b001000,
        ST_SCAN_CMP = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

    // Configuration registers
    logic        case_insensitive_reg;
    logic        whole_line_reg;
    logic        invert_reg;
    logic [2:0]  patterns_in_use_reg;

    // Sequencer and latched beat
    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  idx_reg;
    logic [1:0]        pidx_reg;
    logic [4:0]        bpos_reg;
    logic [7:0]        data_reg;
    logic              eol_reg;

    // Line state and counters
    logic [PATTERN_LEN-1:0]  pm_reg [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0] esf_reg;
    logic [LPOS_W-1:0]       lp_reg;
    logic                    line_hit_reg;
    logic                    raw_reg;
    logic [fslm_pkg::CNT_W-1:0] line_count_reg;
    logic [fslm_pkg::CNT_W-1:0] select_total_reg;
    logic                    ever_reg;

    // Pattern store
    logic [NUM_PATTERNS-1:0] row_valid_reg;
    logic [ROW_W-1:0]        rd_row_reg;
    logic [ROW_W-1:0]        rd_addr;
    logic [ROW_BITS-1:0]     ram_rdata;
    logic [ROW_BITS-1:0]     row_eff;
    logic [ROW_BITS-1:0]     ram_wdata;
    logic                    ram_we;

    // Output register
    logic                       out_valid_reg;
    logic                       out_sel_reg;
    logic [fslm_pkg::CNT_W-1:0] out_num_reg;
    logic [fslm_pkg::CNT_W-1:0] out_cnt_reg;
    logic                       out_any_reg;

    logic                       accept;
    logic [ACT_W-1:0]           act_cnt;
    logic                       last_idx;
    logic                       load_ok;
    logic                       emit_go;
    logic                       sel;
    logic [fslm_pkg::CNT_W-1:0] lc_next;
    logic [fslm_pkg::CNT_W-1:0] st_next;
    logic [PATTERN_LEN-1:0]     pm_new;
    fslm_pkg::cmp_stat_t        stat;
    logic                       cfg_wr;

    // ---------------- APB configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_insensitive_reg <= 1'b0;
            whole_line_reg       <= 1'b0;
            invert_reg           <= 1'b0;
            patterns_in_use_reg  <= 3'd1;
        end
        else if (cfg_wr)
        begin
            case (fslm_pkg::reg_idx_t'(paddr[3:2]))
                fslm_pkg::REG_CASE_INSENSITIVE: case_insensitive_reg <= pwdata[0];
                fslm_pkg::REG_WHOLE_LINE:       whole_line_reg       <= pwdata[0];
                fslm_pkg::REG_INVERT:           invert_reg           <= pwdata[0];
                fslm_pkg::REG_PATTERNS_IN_USE:  patterns_in_use_reg  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (fslm_pkg::reg_idx_t'(paddr[3:2]))
            fslm_pkg::REG_CASE_INSENSITIVE: prdata = {31'd0, case_insensitive_reg};
            fslm_pkg::REG_WHOLE_LINE:       prdata = {31'd0, whole_line_reg};
            fslm_pkg::REG_INVERT:           prdata = {31'd0, invert_reg};
            fslm_pkg::REG_PATTERNS_IN_USE:  prdata = {29'd0, patterns_in_use_reg};
            default:                        prdata = '0;
        endcase
    end

    // ---------------- Sequencer ----------------
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    // Clamp patterns in use to the number of rows built.
    assign act_cnt  = (32'(patterns_in_use_reg) > NUM_PATTERNS) ?
                      ACT_W'(NUM_PATTERNS) : ACT_W'(patterns_in_use_reg);
    assign last_idx = (32'(idx_reg) + 32'd1) == 32'(act_cnt);
    assign load_ok  = (32'(pidx_reg) < NUM_PATTERNS) && (32'(bpos_reg) < PATTERN_LEN);
    assign emit_go  = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (fslm_pkg::cmd_t'(item.command))
                        fslm_pkg::CMD_LOAD:
                            state_next = ST_LOAD_RD;
                        fslm_pkg::CMD_LINE:
                            state_next = (act_cnt != '0) ? ST_SCAN_RD : ST_IDLE;
                        fslm_pkg::CMD_EOL:
                            state_next = (whole_line_reg && act_cnt != '0) ?
                                         ST_SCAN_RD : ST_EMIT;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD_RD:  state_next = load_ok ? ST_LOAD_WR : ST_IDLE;
            ST_LOAD_WR:  state_next = ST_IDLE;
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
            begin
                if (last_idx)
                begin
                    state_next = eol_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:     state_next = emit_go ? ST_IDLE : ST_EMIT;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN_CMP && !last_idx)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Latch the beat on accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pidx_reg <= item.pattern_index;
            bpos_reg <= item.byte_position;
            data_reg <= item.data_byte;
            eol_reg  <= (fslm_pkg::cmd_t'(item.command) == fslm_pkg::CMD_EOL);
        end
    end

    // ---------------- Pattern store ----------------
    // Prefetch the next row while the current one is compared.
    always_comb
    begin
        case (state_reg)
            ST_LOAD_RD:  rd_addr = ROW_W'(pidx_reg);
            ST_SCAN_CMP: rd_addr = last_idx ? idx_reg : idx_reg + 1'b1;
            default:     rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg <= rd_addr;
    end

    // A row never written reads as all zero: an empty pattern.
    assign row_eff = row_valid_reg[rd_row_reg] ? ram_rdata : '0;
    assign ram_we  = (state_reg == ST_LOAD_WR);

    always_comb
    begin
        for (int k = 0; k < PATTERN_LEN; k++)
        begin
            ram_wdata[8*k +: 8] = (32'(bpos_reg) == k) ? data_reg : row_eff[8*k +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (ram_we)
        begin
            row_valid_reg[ROW_W'(pidx_reg)] <= 1'b1;
        end
    end

    fslm_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NUM_PATTERNS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ROW_W'(pidx_reg)),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ---------------- Shared compare unit ----------------
    fslm_cmp #(
        .PATTERN_LEN (PATTERN_LEN),
        .LPOS_W      (LPOS_W)
    ) u_cmp (
        .row     (row_eff),
        .fold_en (case_insensitive_reg),
        .ch      (data_reg),
        .pm_in   (pm_reg[idx_reg]),
        .lpos    (lp_reg),
        .pm_out  (pm_new),
        .stat    (stat)
    );

    // ---------------- Line state and counters ----------------
    assign sel     = raw_reg ^ invert_reg;
    assign lc_next = (line_count_reg == fslm_pkg::COUNT_MAX) ?
                     line_count_reg : line_count_reg + 1'b1;
    assign st_next = (sel && select_total_reg != fslm_pkg::COUNT_MAX) ?
                     select_total_reg + 1'b1 : select_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PATTERNS; p++)
            begin
                pm_reg[p] <= '0;
            end
            esf_reg          <= '1;
            lp_reg           <= '0;
            line_hit_reg     <= 1'b0;
            raw_reg          <= 1'b0;
            line_count_reg   <= '0;
            select_total_reg <= '0;
            ever_reg         <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (fslm_pkg::cmd_t'(item.command))
                            fslm_pkg::CMD_LINE:
                            begin
                                // No active pattern: only the position moves.
                                if (act_cnt == '0 && 32'(lp_reg) < PATTERN_LEN + 1)
                                begin
                                    lp_reg <= lp_reg + 1'b1;
                                end
                            end
                            fslm_pkg::CMD_EOL:
                            begin
                                raw_reg <= whole_line_reg ? 1'b0 : line_hit_reg;
                            end
                            fslm_pkg::CMD_NEWFILE:
                            begin
                                for (int p = 0; p < NUM_PATTERNS; p++)
                                begin
                                    pm_reg[p] <= '0;
                                end
                                esf_reg          <= '1;
                                lp_reg           <= '0;
                                line_hit_reg     <= 1'b0;
                                line_count_reg   <= '0;
                                select_total_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN_CMP:
                begin
                    if (eol_reg)
                    begin
                        if (esf_reg[idx_reg] && stat.len_eq)
                        begin
                            raw_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        pm_reg[idx_reg]  <= pm_new;
                        esf_reg[idx_reg] <= esf_reg[idx_reg] & stat.char_ok;
                        if (stat.hit)
                        begin
                            line_hit_reg <= 1'b1;
                        end
                        // Advance the line position once all patterns have seen the byte.
                        if (last_idx && 32'(lp_reg) < PATTERN_LEN + 1)
                        begin
                            lp_reg <= lp_reg + 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        line_count_reg   <= lc_next;
                        select_total_reg <= st_next;
                        ever_reg         <= ever_reg | raw_reg;
                        for (int p = 0; p < NUM_PATTERNS; p++)
                        begin
                            pm_reg[p] <= '0;
                        end
                        esf_reg      <= '1;
                        lp_reg       <= '0;
                        line_hit_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- Output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_sel_reg <= sel;
            out_num_reg <= lc_next;
            out_cnt_reg <= st_next;
            out_any_reg <= ever_reg | raw_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.line_selected  = out_sel_reg;
    assign result.line_number    = out_num_reg;
    assign result.selected_count = out_cnt_reg;
    assign result.any_match      = out_any_reg;

endmodule
